/* hdl/bur_pkg.sv */
// ----------------------------------------------------------------------------
// bur_pkg: shared types and codes of the bounded undo/redo history
// Field widths, command and status codes, and the control and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bur_pkg;

  localparam int DEPTH_DEFAULT = 8;

  localparam int FUNC_W   = 2;
  localparam int KIND_W   = 3;
  localparam int BRIGHT_W = 16;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 4;
  localparam int REC_W    = KIND_W + BRIGHT_W;

  typedef logic        [FUNC_W-1:0]   func_t;
  typedef logic        [KIND_W-1:0]   kind_t;
  typedef logic signed [BRIGHT_W-1:0] bright_t;
  typedef logic        [STATUS_W-1:0] status_t;
  typedef logic        [CNT_W-1:0]    cnt_t;

  localparam func_t FUNC_ADD  = 2'd0;
  localparam func_t FUNC_UNDO = 2'd1;
  localparam func_t FUNC_REDO = 2'd2;

  localparam status_t ST_ADDED   = 3'd0;
  localparam status_t ST_DROPPED = 3'd1;
  localparam status_t ST_MOVED   = 3'd2;
  localparam status_t ST_NO_UNDO = 3'd3;
  localparam status_t ST_NO_REDO = 3'd4;

  localparam kind_t KIND_NONE          = 3'd0;
  localparam kind_t KIND_ADJUST_COLORS = 3'd1;
  localparam kind_t KIND_ADJUST_UNDO   = 3'd2;
  localparam kind_t KIND_FILTER        = 3'd3;
  localparam kind_t KIND_CROP          = 3'd4;

  localparam cnt_t MAX_DEPTH_RESET = 4'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic load_now;
    logic load_res;
  } bur_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic move;
  } bur_sts_t;

endpackage

/* hdl/bur_cmd_if.sv */
// ----------------------------------------------------------------------------
// bur_cmd_if: command channel
// Carries one history command per transfer: func, op_kind and brightness.
// ----------------------------------------------------------------------------
interface bur_cmd_if import bur_pkg::*; ();
  logic    valid;
  logic    ready;
  func_t   func;
  kind_t   op_kind;
  bright_t brightness;

  modport source (output valid, func, op_kind, brightness, input ready);
  modport sink   (input valid, func, op_kind, brightness, output ready);
endinterface

/* hdl/bur_rsp_if.sv */
// ----------------------------------------------------------------------------
// bur_rsp_if: result channel
// Carries one result per command: status, reported record and entry count.
// ----------------------------------------------------------------------------
interface bur_rsp_if import bur_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  kind_t   op_kind_out;
  bright_t brightness_out;
  cnt_t    entries;

  modport source (output valid, status, op_kind_out, brightness_out, entries, input ready);
  modport sink   (input valid, status, op_kind_out, brightness_out, entries, output ready);
endinterface

/* hdl/bur_cfg_if.sv */
// ----------------------------------------------------------------------------
// bur_cfg_if: configuration write channel
// Carries a new value of the max_depth register per transfer.
// ----------------------------------------------------------------------------
interface bur_cfg_if import bur_pkg::*; ();
  logic valid;
  logic ready;
  cnt_t max_depth;

  modport source (output valid, max_depth, input ready);
  modport sink   (input valid, max_depth, output ready);
endinterface

/* hdl/bur_ram.sv */
// ----------------------------------------------------------------------------
// bur_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bur_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/bur_ctrl.sv */
// ----------------------------------------------------------------------------
// bur_ctrl: command sequencer
// Takes a command, lets the datapath execute it, and loads the result
// register once it is free.
// ----------------------------------------------------------------------------
module bur_ctrl import bur_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  bur_sts_t sts,
  output bur_ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        // A result without a record read can go out right away.
        if (!sts.move && out_free) begin
          ctl.load_now = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          ctl.load_res = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_now || ctl.load_res) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> state == S_EXEC)
    else $error("accepted command did not enter execution");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.load_now || ctl.load_res |=> rsp_valid)
    else $error("loaded result not presented");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) && rsp_valid && !rsp_ready |=> state == S_LOAD)
    else $error("result overwritten while receiver stalls");

endmodule

/* hdl/bur_dp.sv */
// ----------------------------------------------------------------------------
// bur_dp: history datapath
// Ring pointers, entry count, limit register, record RAM and result register.
// ----------------------------------------------------------------------------
module bur_dp import bur_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  cnt_t     cfg_max_depth,
  input  func_t    func,
  input  kind_t    op_kind,
  input  bright_t  brightness,
  input  bur_ctl_t ctl,
  output bur_sts_t sts,
  output status_t  status,
  output kind_t    op_kind_out,
  output bright_t  brightness_out,
  output cnt_t     entries
);

  // Wide enough for a slot index plus any count or drop amount.
  localparam int XW = SW + 5;

  logic [SW-1:0] oldest;
  logic [SW-1:0] current;
  logic [SW-1:0] newest;
  cnt_t          count;
  cnt_t          max_depth;

  func_t   in_func;
  kind_t   in_kind;
  bright_t in_bright;

  status_t res_status;
  logic    res_move;
  logic    res_undo;

  cnt_t          lim;
  logic [SW-1:0] cur_next;
  logic [SW-1:0] cur_prev;
  logic [XW-1:0] fut_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] add_cnt_x;
  logic [XW-1:0] old_sum;
  logic [SW-1:0] add_slot;
  logic [SW-1:0] add_oldest;
  cnt_t          add_cnt;
  status_t       add_status;

  logic [SW-1:0] oldest_next;
  logic [SW-1:0] current_next;
  logic [SW-1:0] newest_next;
  cnt_t          count_next;
  status_t       st_c;
  logic          move_c;

  logic [REC_W-1:0] rdata;
  kind_t            rd_kind;

  always_comb begin
    if (max_depth == '0) begin
      lim = CNT_W'(1);
    end else if (32'(max_depth) > DEPTH) begin
      lim = CNT_W'(DEPTH);
    end else begin
      lim = max_depth;
    end

    cur_next = (current == SW'(DEPTH - 1)) ? '0 : current + SW'(1);
    cur_prev = (current == '0) ? SW'(DEPTH - 1) : current - SW'(1);

    // Entries past the current one, walking the ring forward.
    if (newest >= current) begin
      fut_x = XW'(newest) - XW'(current);
    end else begin
      fut_x = XW'(newest) + XW'(DEPTH) - XW'(current);
    end
    cnt_x = XW'(count);

    if (count == '0) begin
      add_slot  = oldest;
      add_cnt_x = XW'(1);
    end else begin
      add_slot  = cur_next;
      add_cnt_x = ((fut_x < cnt_x) ? cnt_x - fut_x : XW'(1)) + XW'(1);
    end

    old_sum = XW'(oldest) + add_cnt_x - XW'(lim);
    if (old_sum >= XW'(DEPTH)) begin
      old_sum = old_sum - XW'(DEPTH);
    end
    if (add_cnt_x > XW'(lim)) begin
      add_oldest = old_sum[SW-1:0];
      add_cnt    = lim;
      add_status = ST_DROPPED;
    end else begin
      add_oldest = oldest;
      add_cnt    = add_cnt_x[CNT_W-1:0];
      add_status = ST_ADDED;
    end

    oldest_next  = oldest;
    current_next = current;
    newest_next  = newest;
    count_next   = count;
    move_c       = 1'b0;
    priority if (in_func == FUNC_ADD) begin
      oldest_next  = add_oldest;
      current_next = add_slot;
      newest_next  = add_slot;
      count_next   = add_cnt;
      st_c         = add_status;
    end else if (in_func == FUNC_UNDO) begin
      if ((count == '0) || (current == oldest)) begin
        st_c = ST_NO_UNDO;
      end else begin
        current_next = cur_prev;
        move_c       = 1'b1;
        st_c         = ST_MOVED;
      end
    end else if (in_func == FUNC_REDO) begin
      if ((count == '0) || (current == newest)) begin
        st_c = ST_NO_REDO;
      end else begin
        current_next = cur_next;
        move_c       = 1'b1;
        st_c         = ST_MOVED;
      end
    end else begin
      st_c = ST_NO_REDO;
    end
  end

  assign sts.move = move_c;

  bur_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ctl.exec && (in_func == FUNC_ADD)),
    .waddr (add_slot),
    .wdata ({in_kind, in_bright}),
    .re    (ctl.exec && move_c),
    .raddr (current_next),
    .rdata (rdata)
  );

  assign rd_kind = rdata[REC_W-1 -: KIND_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest    <= '0;
      current   <= '0;
      newest    <= '0;
      count     <= '0;
      max_depth <= MAX_DEPTH_RESET;
    end else begin
      if (cfg_we) begin
        max_depth <= cfg_max_depth;
      end
      if (ctl.exec) begin
        oldest  <= oldest_next;
        current <= current_next;
        newest  <= newest_next;
        count   <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      in_func   <= func;
      in_kind   <= op_kind;
      in_bright <= brightness;
    end
    if (ctl.exec) begin
      res_status <= st_c;
      res_move   <= move_c;
      res_undo   <= (in_func == FUNC_UNDO);
    end
    if (ctl.load_now) begin
      status         <= st_c;
      op_kind_out    <= KIND_NONE;
      brightness_out <= '0;
      entries        <= count_next;
    end else if (ctl.load_res) begin
      status  <= res_status;
      entries <= count;
      if (res_move) begin
        // An undone color adjustment is reported as its undo kind.
        op_kind_out    <= (res_undo && (rd_kind == KIND_ADJUST_COLORS)) ?
                          KIND_ADJUST_UNDO : rd_kind;
        brightness_out <= bright_t'(rdata[BRIGHT_W-1:0]);
      end else begin
        op_kind_out    <= KIND_NONE;
        brightness_out <= '0;
      end
    end
  end

  a_add_bounds: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && (in_func == FUNC_ADD) |=>
      (count != '0) && (current == newest) && (count <= $past(lim)))
    else $error("add left the history out of bounds");

  a_empty_slots: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (current == oldest) && (newest == oldest))
    else $error("empty history with scattered pointers");

  a_move_count: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && move_c |=> count == $past(count))
    else $error("undo or redo changed the entry count");

endmodule

/* hdl/bounded_undo_redo_history.sv */
// ----------------------------------------------------------------------------
// bounded_undo_redo_history: bounded undo/redo history of edit records
// Keeps a ring of edit records and answers add, undo and redo commands.
// ----------------------------------------------------------------------------
// Channels: cmd takes one command per transfer (func, op_kind, brightness);
// rsp returns exactly one result per command (status, op_kind_out,
// brightness_out, entries); cfg writes the max_depth limit and is always
// ready. Write cfg only while no command is in flight.
// Timing: a command is taken in the idle cycle and executed in the next
// one; an add or a failed move has its result loaded into the output
// register at the end of the execute cycle if that register is free, else
// in the load state. A successful undo or redo reads its record from the
// ring RAM's registered read port and is loaded in the load state. The
// sequencer handles one command at a time, so the block takes no new
// command until the result of the last one has been loaded.
// Reset: the history is empty, all pointers are zero, max_depth is 3 and
// no result is pending. The ring itself is not cleared; only written
// records are ever read.
// Stall: a finished result waits in the output register; a command that
// completes while it is still held waits in the sequencer, and cmd stays
// not ready until the result has been taken.
// ----------------------------------------------------------------------------
module bounded_undo_redo_history import bur_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  bur_cmd_if.sink  cmd,
  bur_rsp_if.source rsp,
  bur_cfg_if.sink  cfg
);

  bur_ctl_t ctl;
  bur_sts_t sts;

  assign cfg.ready = 1'b1;

  bur_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  bur_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg.valid),
    .cfg_max_depth  (cfg.max_depth),
    .func           (cmd.func),
    .op_kind        (cmd.op_kind),
    .brightness     (cmd.brightness),
    .ctl            (ctl),
    .sts            (sts),
    .status         (rsp.status),
    .op_kind_out    (rsp.op_kind_out),
    .brightness_out (rsp.brightness_out),
    .entries        (rsp.entries)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bounded undo/redo history
// Drives add, undo, redo and unused commands under random idling on both
// channels, replays every accepted command on a behavioral copy of the
// history, and checks each result field against it. Covers the reset depth
// limit and several written limits, including 0 and 15.
// ----------------------------------------------------------------------------
module tb;
  import bur_pkg::*;

  localparam int unsigned HIST_DEPTH = DEPTH_DEFAULT;
  localparam func_t       FUNC_UNUSED = 2'd3;
  localparam int unsigned STALL_AT = 320;
  localparam int unsigned STALL_CYCLES = 120;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES = 6;

  typedef struct packed {
    func_t   func;
    kind_t   kind;
    bright_t bright;
  } edit_cmd_t;

  typedef struct packed {
    status_t status;
    kind_t   kind;
    bright_t bright;
    cnt_t    entries;
  } edit_rsp_t;

  logic clk;
  logic rst;

  bur_cmd_if cmd ();
  bur_rsp_if rsp ();
  bur_cfg_if cfg ();

  bounded_undo_redo_history i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp),
    .cfg (cfg)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Behavioral copy of the history.
  kind_t       hist_kind [HIST_DEPTH];
  bright_t     hist_bright [HIST_DEPTH];
  int unsigned hist_oldest;
  int unsigned hist_current;
  int unsigned hist_newest;
  int unsigned hist_count;
  cnt_t        depth_setting;

  edit_cmd_t   edit_queue [$];
  edit_rsp_t   reply_queue [$];

  int unsigned n_queued;
  int unsigned n_cmds;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_adds;
  int unsigned n_dropped;
  int unsigned n_moves;
  int unsigned n_refused;
  int unsigned n_settings;

  int unsigned idle_left;
  int unsigned hold_left;
  logic        tx_steady;
  logic        rx_steady;
  int unsigned stall_left;
  logic        stall_done;
  int unsigned quiet_cycles;

  function automatic edit_rsp_t history_apply(edit_cmd_t c);
    edit_rsp_t   r;
    int unsigned lim;
    int unsigned slot;
    int unsigned future;
    r = '0;
    lim = depth_setting;
    if (lim < 1) lim = 1;
    if (lim > HIST_DEPTH) lim = HIST_DEPTH;
    case (c.func)
      FUNC_ADD: begin
        if (hist_count == 0) begin
          slot = hist_oldest;
          hist_count = 1;
        end else begin
          // Everything after the current entry is thrown away first.
          future = (hist_newest + HIST_DEPTH - hist_current) % HIST_DEPTH;
          hist_count = (future < hist_count) ? hist_count - future : 1;
          slot = (hist_current + 1) % HIST_DEPTH;
          hist_count++;
        end
        hist_kind[slot] = c.kind;
        hist_bright[slot] = c.bright;
        hist_current = slot;
        hist_newest = slot;
        r.status = ST_ADDED;
        if (hist_count > lim) begin
          hist_oldest = (hist_oldest + hist_count - lim) % HIST_DEPTH;
          hist_count = lim;
          r.status = ST_DROPPED;
        end
      end
      FUNC_UNDO: begin
        if (hist_count == 0 || hist_current == hist_oldest) begin
          r.status = ST_NO_UNDO;
        end else begin
          hist_current = (hist_current + HIST_DEPTH - 1) % HIST_DEPTH;
          r.kind = hist_kind[hist_current];
          r.bright = hist_bright[hist_current];
          if (r.kind == KIND_ADJUST_COLORS) r.kind = KIND_ADJUST_UNDO;
          r.status = ST_MOVED;
        end
      end
      FUNC_REDO: begin
        if (hist_count == 0 || hist_current == hist_newest) begin
          r.status = ST_NO_REDO;
        end else begin
          hist_current = (hist_current + 1) % HIST_DEPTH;
          r.kind = hist_kind[hist_current];
          r.bright = hist_bright[hist_current];
          r.status = ST_MOVED;
        end
      end
      default: begin
        r.status = ST_NO_REDO;
      end
    endcase
    r.entries = cnt_t'(hist_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want_v);
    $display("result %0d: %s is %0d, should be %0d", n_checked, what, got, want_v);
    n_errors++;
  endtask

  // Command driver: valid stays up until the transfer, then a random idle gap, which may be empty.
  always @(posedge clk) begin : drive_cmd
    edit_cmd_t seen;
    edit_rsp_t want;
    logic      drive;
    if (rst) begin
      cmd.valid <= 1'b0;
      idle_left = 0;
      tx_steady = 1'b0;
    end else begin
      drive = cmd.valid;
      if (cmd.valid && cmd.ready) begin
        seen.func = cmd.func;
        seen.kind = cmd.op_kind;
        seen.bright = cmd.brightness;
        want = history_apply(seen);
        reply_queue.push_back(want);
        edit_queue.delete(0);
        n_cmds <= n_cmds + 1;
        if (seen.func == FUNC_ADD) n_adds++;
        if (want.status == ST_DROPPED) n_dropped++;
        if (want.status == ST_MOVED) n_moves++;
        if (want.status == ST_NO_UNDO || want.status == ST_NO_REDO) n_refused++;
        idle_left = tx_steady ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
        drive = 1'b0;
      end
      if (!drive) begin
        if (idle_left != 0) begin
          idle_left--;
        end else if (edit_queue.size() != 0) begin
          drive = 1'b1;
          cmd.func <= edit_queue[0].func;
          cmd.op_kind <= edit_queue[0].kind;
          cmd.brightness <= edit_queue[0].bright;
        end
      end
      cmd.valid <= drive;
    end
  end

  // Result monitor and checker.
  always @(posedge clk) begin : check_rsp
    edit_rsp_t want;
    logic      take;
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_left = 0;
      rx_steady = 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        n_checked++;
        if (reply_queue.size() == 0) begin
          report_mismatch("unrequested result, status", rsp.status, -1);
        end else begin
          want = reply_queue.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
          if (rsp.op_kind_out !== want.kind)
            report_mismatch("op_kind_out", rsp.op_kind_out, want.kind);
          if (rsp.brightness_out !== want.bright)
            report_mismatch("brightness_out", rsp.brightness_out, want.bright);
          if (rsp.entries !== want.entries)
            report_mismatch("entries", rsp.entries, want.entries);
        end
        hold_left = rx_steady ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
      end
      take = 1'b1;
      if (hold_left != 0) begin
        hold_left--;
        take = 1'b0;
      end
      if (stall_left != 0) take = 1'b0;
      rsp.ready <= take;
    end
  end

  // One long receiver hold-off while commands keep coming, so the block
  // backs up and stalls its command input.
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && n_cmds >= STALL_AT) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) ||
                 (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, reply_queue.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_edit(func_t f, kind_t k, bright_t b);
    edit_cmd_t c;
    c.func = f;
    c.kind = k;
    c.bright = b;
    edit_queue.push_back(c);
    n_queued++;
  endtask

  function automatic kind_t rand_kind();
    if ($urandom_range(0, 9) == 0) return kind_t'($urandom_range(5, 7));
    return kind_t'($urandom_range(0, 4));
  endfunction

  function automatic bright_t rand_bright();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return bright_t'($urandom);
    endcase
  endfunction

  function automatic func_t rand_func();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return FUNC_ADD;
    if (pick < 7) return FUNC_UNDO;
    if (pick < 9) return FUNC_REDO;
    return FUNC_UNUSED;
  endfunction

  // Waits until every command has been answered, then lets the block settle.
  task automatic wait_idle();
    while (edit_queue.size() != 0 || cmd.valid || reply_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_depth(cnt_t v);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.max_depth <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    depth_setting = v;
    n_settings++;
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned stop;
    stop = n_queued + n;
    while (n_queued < stop) begin
      if ($urandom_range(0, 3) == 0) begin
        // A run of edits, then a walk back toward the oldest entry and forward.
        repeat ($urandom_range(1, 10)) push_edit(FUNC_ADD, rand_kind(), rand_bright());
        repeat ($urandom_range(1, 9)) push_edit(FUNC_UNDO, rand_kind(), rand_bright());
        repeat ($urandom_range(1, 9)) push_edit(FUNC_REDO, rand_kind(), rand_bright());
      end else begin
        push_edit(rand_func(), rand_kind(), rand_bright());
      end
    end
  endtask

  initial begin
    cnt_t phase_depth [10];
    phase_depth = '{4'd8, 4'd1, 4'd15, 4'd4, 4'd0, 4'd2, 4'd6, 4'd3, 4'd7, 4'd5};
    clk = 1'b0;
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.func = FUNC_ADD;
    cmd.op_kind = KIND_NONE;
    cmd.brightness = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.max_depth = MAX_DEPTH_RESET;
    hist_oldest = 0;
    hist_current = 0;
    hist_newest = 0;
    hist_count = 0;
    depth_setting = MAX_DEPTH_RESET;
    n_queued = 0;
    n_cmds = 0;
    n_checked = 0;
    n_errors = 0;
    n_adds = 0;
    n_dropped = 0;
    n_moves = 0;
    n_refused = 0;
    n_settings = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset limit of three: empty history, field extremes, both ends of the
    // history, the adjust-colors report and a prune of the future entries.
    push_edit(FUNC_UNDO, KIND_NONE, 16'sh0000);
    push_edit(FUNC_REDO, KIND_NONE, 16'sh0000);
    push_edit(FUNC_UNUSED, 3'd7, 16'shFFFF);
    push_edit(FUNC_ADD, KIND_NONE, 16'sh8000);
    push_edit(FUNC_ADD, KIND_ADJUST_COLORS, 16'sh7FFF);
    push_edit(FUNC_ADD, KIND_CROP, 16'sh0000);
    push_edit(FUNC_ADD, 3'd7, 16'shFFFF);
    push_edit(FUNC_UNDO, KIND_NONE, 16'sh0000);
    push_edit(FUNC_UNDO, KIND_NONE, 16'sh0000);
    push_edit(FUNC_UNDO, KIND_NONE, 16'sh0000);
    push_edit(FUNC_REDO, KIND_NONE, 16'sh0000);
    push_edit(FUNC_REDO, KIND_NONE, 16'sh0000);
    push_edit(FUNC_REDO, KIND_NONE, 16'sh0000);
    push_edit(FUNC_UNDO, KIND_NONE, 16'sh0000);
    push_edit(FUNC_ADD, 3'd5, 16'sh5555);
    push_edit(FUNC_UNUSED, KIND_NONE, 16'sh0000);
    wait_idle();

    // A limit of zero behaves as one.
    set_depth(4'd0);
    push_edit(FUNC_ADD, KIND_FILTER, 16'shAAAA);
    push_edit(FUNC_UNDO, KIND_NONE, 16'sh0000);
    wait_idle();

    // A limit above the ring size behaves as the ring size; then lowering it
    // makes the next add drop every surplus entry at once.
    set_depth(4'd15);
    repeat (8) push_edit(FUNC_ADD, rand_kind(), rand_bright());
    wait_idle();
    set_depth(4'd2);
    push_edit(FUNC_ADD, KIND_ADJUST_UNDO, 16'sh7F00);

    foreach (phase_depth[p]) begin
      wait_idle();
      set_depth(phase_depth[p]);
      random_phase(200);
    end
    wait_idle();

    $display("%0d commands under %0d written limits, %0d results checked, %0d errors",
             n_cmds, n_settings, n_checked, n_errors);
    $display("%0d adds (%0d dropped the oldest), %0d undo/redo moves, %0d refused",
             n_adds, n_dropped, n_moves, n_refused);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/bur_pkg.sv
hdl/bur_cmd_if.sv
hdl/bur_rsp_if.sv
hdl/bur_cfg_if.sv
hdl/bur_ram.sv
hdl/bur_ctrl.sv
hdl/bur_dp.sv
hdl/bounded_undo_redo_history.sv
verif/tb.sv
